// ===== design/epoch_seconds_to_calendar_date_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_MACROS_SVH

// same-cycle implication
`define ESC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: package
// Types, constants and calendar tables shared by the design files.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int unsigned AccW = 31;

    localparam logic [AccW-1:0] SecsPerDay  = 31'd86400;
    localparam logic [AccW-1:0] SecsPerHour = 31'd3600;
    localparam logic [AccW-1:0] SecsPerMin  = 31'd60;
    localparam logic [AccW-1:0] DaysPerWeek = 31'd7;
    localparam logic [10:0]     BaseYear    = 11'd1970;
    localparam logic [14:0]     EpochWday   = 15'd4;

    // top shift of the divisor for each restoring division, and the last month index
    localparam logic [3:0] DayTopBit  = 4'd14;
    localparam logic [3:0] HourTopBit = 4'd4;
    localparam logic [3:0] MinTopBit  = 4'd5;
    localparam logic [3:0] WdayTopBit = 4'd11;
    localparam logic [3:0] LastMonth  = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_HOUR,
        S_MIN,
        S_WDAY,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [5:0]  seconds_of_minute;
        logic [5:0]  minutes_of_hour;
        logic [4:0]  hours_of_day;
        logic [4:0]  day_of_month;
        logic [3:0]  month_index;
        logic [10:0] year_number;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } t_result;

    // years reachable here run 1970..2038, where the century rules change nothing
    function automatic logic is_leap(input logic [10:0] yr);
        return (yr[1:0] == 2'd0);
    endfunction

    function automatic logic [8:0] days_in_year(input logic [10:0] yr);
        return is_leap(yr) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [8:0] month_start(input logic lp, input logic [3:0] mo);
        logic [8:0] v;
        case (mo)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = lp ? 9'd60  : 9'd59;
            4'd3:    v = lp ? 9'd91  : 9'd90;
            4'd4:    v = lp ? 9'd121 : 9'd120;
            4'd5:    v = lp ? 9'd152 : 9'd151;
            4'd6:    v = lp ? 9'd182 : 9'd181;
            4'd7:    v = lp ? 9'd213 : 9'd212;
            4'd8:    v = lp ? 9'd244 : 9'd243;
            4'd9:    v = lp ? 9'd274 : 9'd273;
            4'd10:   v = lp ? 9'd305 : 9'd304;
            4'd11:   v = lp ? 9'd335 : 9'd334;
            default: v = lp ? 9'd366 : 9'd365;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/esc_if.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: channel interfaces
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] seconds_since_epoch;

    modport source (output valid, output seconds_since_epoch, input ready);
    modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface esc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  seconds_of_minute;
    logic [5:0]  minutes_of_hour;
    logic [4:0]  hours_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [10:0] year_number;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;

    modport source (
        output valid, input ready,
        output seconds_of_minute, output minutes_of_hour, output hours_of_day,
        output day_of_month, output month_index, output year_number,
        output weekday, output day_of_year
    );
    modport sink (
        input valid, output ready,
        input seconds_of_minute, input minutes_of_hour, input hours_of_day,
        input day_of_month, input month_index, input year_number,
        input weekday, input day_of_year
    );
endinterface

`default_nettype wire

// ===== design/esc_cmp_sub.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: compare-subtract unit
// Shared unit: flags a >= b and gives a - b when set, a otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_cmp_sub (
    input  wire logic [esc_pkg::AccW-1:0] i_a,
    input  wire logic [esc_pkg::AccW-1:0] i_b,
    output logic                          o_ge,
    output logic [esc_pkg::AccW-1:0]      o_res
);

    logic [esc_pkg::AccW:0] diff;

    assign diff  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge  = ~diff[esc_pkg::AccW];
    assign o_res = o_ge ? diff[esc_pkg::AccW-1:0] : i_a;

endmodule

`default_nettype wire

// ===== design/epoch_seconds_to_calendar_date_unit.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date unit
// Converts a 31-bit count of seconds since 1970-01-01 00:00 UTC to
// time of day, weekday, day of year, year, month and day of month.
//
// i_in  : sink channel, one seconds word per conversion.
// o_out : source channel, one date word per input word.
// Every step runs through one compare-subtract unit under a sequencer:
//   seconds / 86400, then hours, minutes and the weekday remainder by
//   restoring division, then years stepped off from 1970 upward, then
//   months probed from December down, then the hand-off to the output.
// One word is in work at a time, and i_in.ready is high only while the
// sequencer idles.
// The result sits in an output register, so a new word is taken while it
// waits; if the receiver stalls, the next result holds in the last state
// until the register frees.
// Reset (i_rst_n low, synchronous) empties the output register and
// returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_to_calendar_date_unit_macros.svh"

module epoch_seconds_to_calendar_date_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    esc_in_if.sink    i_in,
    esc_out_if.source o_out
);

    localparam int unsigned W = esc_pkg::AccW;

    esc_pkg::t_state  r_state, n_state;
    logic [W-1:0]     r_acc, n_acc;
    logic [14:0]      r_quo, n_quo;
    logic [3:0]       r_k, n_k;
    logic [14:0]      r_days, n_days;
    logic             r_lp, n_lp;
    esc_pkg::t_result r_work, n_work;
    esc_pkg::t_result r_out;
    logic             r_out_valid, n_out_valid;
    logic             load_out;

    logic [W-1:0] sub_b;
    logic [W-1:0] sub_res;
    logic         sub_ge;
    logic [14:0]  quo_shift;

    esc_cmp_sub u_cmp_sub (
        .i_a   (r_acc),
        .i_b   (sub_b),
        .o_ge  (sub_ge),
        .o_res (sub_res)
    );

    assign quo_shift = {r_quo[13:0], sub_ge};
    assign i_in.ready = (r_state == esc_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_k         = r_k;
        n_days      = r_days;
        n_lp        = r_lp;
        n_work      = r_work;
        n_out_valid = r_out_valid;
        load_out    = 1'b0;
        sub_b       = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            esc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_acc   = i_in.seconds_since_epoch;
                    n_quo   = '0;
                    n_k     = esc_pkg::DayTopBit;
                    n_state = esc_pkg::S_DAYS;
                end
            end
            esc_pkg::S_DAYS: begin
                sub_b = esc_pkg::SecsPerDay << r_k;
                n_acc = sub_res;
                n_quo = quo_shift;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_days  = quo_shift;
                    n_quo   = '0;
                    n_k     = esc_pkg::HourTopBit;
                    n_state = esc_pkg::S_HOUR;
                end
            end
            esc_pkg::S_HOUR: begin
                sub_b = esc_pkg::SecsPerHour << r_k;
                n_acc = sub_res;
                n_quo = quo_shift;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_work.hours_of_day = quo_shift[4:0];
                    n_quo   = '0;
                    n_k     = esc_pkg::MinTopBit;
                    n_state = esc_pkg::S_MIN;
                end
            end
            esc_pkg::S_MIN: begin
                sub_b = esc_pkg::SecsPerMin << r_k;
                n_acc = sub_res;
                n_quo = quo_shift;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_work.minutes_of_hour   = quo_shift[5:0];
                    n_work.seconds_of_minute = sub_res[5:0];
                    n_acc   = W'(r_days + esc_pkg::EpochWday);
                    n_k     = esc_pkg::WdayTopBit;
                    n_state = esc_pkg::S_WDAY;
                end
            end
            esc_pkg::S_WDAY: begin
                sub_b = esc_pkg::DaysPerWeek << r_k;
                n_acc = sub_res;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_work.weekday     = sub_res[2:0];
                    n_acc              = W'(r_days);
                    n_work.year_number = esc_pkg::BaseYear;
                    n_state            = esc_pkg::S_YEAR;
                end
            end
            esc_pkg::S_YEAR: begin
                sub_b = W'(esc_pkg::days_in_year(r_work.year_number));
                if (sub_ge) begin
                    n_acc              = sub_res;
                    n_work.year_number = r_work.year_number + 11'd1;
                end else begin
                    n_work.day_of_year = r_acc[8:0];
                    n_lp               = esc_pkg::is_leap(r_work.year_number);
                    n_work.month_index = esc_pkg::LastMonth;
                    n_state            = esc_pkg::S_MONTH;
                end
            end
            esc_pkg::S_MONTH: begin
                sub_b = W'(esc_pkg::month_start(r_lp, r_work.month_index));
                if (sub_ge) begin
                    n_work.day_of_month = sub_res[4:0];
                    n_state             = esc_pkg::S_DONE;
                end else begin
                    n_work.month_index = r_work.month_index - 4'd1;
                end
            end
            esc_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = esc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = esc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        r_k    <= n_k;
        r_days <= n_days;
        r_lp   <= n_lp;
        r_work <= n_work;
        if (load_out) begin
            r_out <= r_work;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.seconds_of_minute = r_out.seconds_of_minute;
    assign o_out.minutes_of_hour   = r_out.minutes_of_hour;
    assign o_out.hours_of_day      = r_out.hours_of_day;
    assign o_out.day_of_month      = r_out.day_of_month;
    assign o_out.month_index       = r_out.month_index;
    assign o_out.year_number       = r_out.year_number;
    assign o_out.weekday           = r_out.weekday;
    assign o_out.day_of_year       = r_out.day_of_year;

    `ESC_ASSERT_NEXT(a_busy_after_accept, i_in.valid && i_in.ready, !i_in.ready, "ready after accept")
    `ESC_ASSERT_IMPL(a_year_range, r_state == esc_pkg::S_YEAR, r_work.year_number <= 11'd2038, "year overrun")
    `ESC_ASSERT_IMPL(a_date_range, r_state == esc_pkg::S_DONE, (r_work.month_index <= 4'd11) && (r_work.day_of_month <= 5'd30), "date out of range")
    `ESC_ASSERT_IMPL(a_time_range, o_out.valid, (o_out.seconds_of_minute < 6'd60) && (o_out.minutes_of_hour < 6'd60) && (o_out.hours_of_day < 5'd24) && (o_out.weekday < 3'd7), "time out of range")

endmodule

`default_nettype wire

// ===== tb/esc_date_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date: result checker
// Watches both channels of the unit. Every seconds word taken in is turned
// into the expected date word and queued; every date word handed out is
// compared field by field with the oldest queued date.
// ----------------------------------------------------------------------------

module esc_date_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    esc_in_if           i_in_mon,
    esc_out_if          i_out_mon,
    output int unsigned o_fail_count,
    output int unsigned o_pending_count,
    output int unsigned o_words_checked,
    output int unsigned o_leap_year_words,
    output int unsigned o_leap_day_words
);

    localparam int unsigned SecsPerDay   = 86400;
    localparam int unsigned SecsPerHour  = 3600;
    localparam int unsigned SecsPerMin   = 60;
    localparam int unsigned FirstYear    = 1970;
    localparam int unsigned EpochWeekday = 4;

    esc_pkg::t_result expected_dates[$];
    int unsigned      fail_cnt      = 0;
    int unsigned      checked_cnt   = 0;
    int unsigned      leap_year_cnt = 0;
    int unsigned      leap_day_cnt  = 0;

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic esc_pkg::t_result convert_seconds(input logic [30:0] secs);
        esc_pkg::t_result r;
        int unsigned      days;
        int unsigned      clk_secs;
        int unsigned      yr;
        int unsigned      mo;
        int unsigned      mlen;
        bit               lp;
        days     = secs / SecsPerDay;
        clk_secs = secs % SecsPerDay;
        r.hours_of_day      = 5'(clk_secs / SecsPerHour);
        r.minutes_of_hour   = 6'((clk_secs % SecsPerHour) / SecsPerMin);
        r.seconds_of_minute = 6'(clk_secs % SecsPerMin);
        r.weekday           = 3'((days + EpochWeekday) % 7);
        yr = FirstYear;
        while (days >= (leap_year(yr) ? 366 : 365)) begin
            days -= leap_year(yr) ? 366 : 365;
            yr++;
        end
        r.year_number = 11'(yr);
        r.day_of_year = 9'(days);
        lp   = leap_year(yr);
        mo   = 0;
        mlen = 31;
        while (days >= mlen) begin
            days -= mlen;
            mo++;
            if (mo == 1) begin
                mlen = lp ? 29 : 28;
            end else if (mo == 3 || mo == 5 || mo == 8 || mo == 10) begin
                mlen = 30;
            end else begin
                mlen = 31;
            end
        end
        r.month_index  = 4'(mo);
        r.day_of_month = 5'(days);
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        esc_pkg::t_result want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                expected_dates.push_back(convert_seconds(i_in_mon.seconds_since_epoch));
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_dates.size() == 0) begin
                    $error("date word with no seconds word pending");
                    fail_cnt++;
                end else begin
                    want = expected_dates.pop_front();
                    compare_field("seconds_of_minute", want.seconds_of_minute,
                                  i_out_mon.seconds_of_minute);
                    compare_field("minutes_of_hour", want.minutes_of_hour,
                                  i_out_mon.minutes_of_hour);
                    compare_field("hours_of_day", want.hours_of_day, i_out_mon.hours_of_day);
                    compare_field("day_of_month", want.day_of_month, i_out_mon.day_of_month);
                    compare_field("month_index", want.month_index, i_out_mon.month_index);
                    compare_field("year_number", want.year_number, i_out_mon.year_number);
                    compare_field("weekday", want.weekday, i_out_mon.weekday);
                    compare_field("day_of_year", want.day_of_year, i_out_mon.day_of_year);
                    checked_cnt++;
                    if (leap_year(want.year_number)) begin
                        leap_year_cnt++;
                    end
                    if (want.month_index == 4'd1 && want.day_of_month == 5'd28) begin
                        leap_day_cnt++;
                    end
                end
            end
        end
        o_fail_count      <= fail_cnt;
        o_pending_count   <= expected_dates.size();
        o_words_checked   <= checked_cnt;
        o_leap_year_words <= leap_year_cnt;
        o_leap_day_words  <= leap_day_cnt;
    end

endmodule

// ===== tb/tb_epoch_seconds_to_calendar_date_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar date unit: testbench top
// Drives seconds words into the unit (calendar edges first, then random
// words weighted toward day and month boundaries), stalls the result side
// at random and once for a long hold-off, and reports the checker verdict.
// ----------------------------------------------------------------------------

module tb_epoch_seconds_to_calendar_date_unit;

    localparam int unsigned RandomWords = 1150;
    localparam int unsigned HoldStart   = 30000;
    localparam int unsigned HoldCycles  = 1500;
    localparam int unsigned CalmStart   = 80000;
    localparam int unsigned CalmEnd     = 100000;
    localparam int unsigned DrainCycles = 130;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned words_checked;
    int unsigned leap_year_words;
    int unsigned leap_day_words;

    esc_in_if  in_ch ();
    esc_out_if out_ch ();

    epoch_seconds_to_calendar_date_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    esc_date_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_mon          (in_ch),
        .i_out_mon         (out_ch),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count),
        .o_words_checked   (words_checked),
        .o_leap_year_words (leap_year_words),
        .o_leap_day_words  (leap_day_words)
    );

    always #6 i_clk = ~i_clk;

    task automatic send_word(input logic [30:0] w, input bit with_gaps);
        while (with_gaps && $urandom_range(99) < 9) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.seconds_since_epoch <= w;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin : stimulus
        logic [30:0] directed_words[$];
        int unsigned n;
        int unsigned kind;
        int unsigned day;
        int unsigned secs;
        int unsigned yr;
        int unsigned mo;
        in_ch.valid               = 1'b0;
        in_ch.seconds_since_epoch = '0;
        directed_words = '{
            31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
            31'h4000_0000, 31'h2AAA_AAAA, 31'h5555_5555,
            31'd31535999, 31'd31536000,
            31'd68169600, 31'd68256000, 31'd84067200, 31'd84153600, 31'd94694399,
            31'd52531200,
            31'd951782400, 31'd951868800, 31'd978307199,
            31'd2145916799, 31'd2145916800, 31'd2147483647
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_words[k]) begin
            send_word(directed_words[k], 1'b1);
        end

        for (n = 0; n < RandomWords; n++) begin
            kind = $urandom_range(9);
            if (kind < 4) begin
                send_word(31'($urandom), !(n >= 400 && n < 600));
            end else begin
                if (kind < 7) begin
                    day = $urandom_range(24854);
                end else begin
                    yr  = $urandom_range(2037, 1970);
                    mo  = $urandom_range(11);
                    day = (yr - 1970) * 365 + (yr - 1969) / 4 + (mo * 367) / 12
                          + $urandom_range(4);
                    day = (day >= 2) ? day - 2 : 0;
                end
                if ($urandom_range(1)) begin
                    secs = $urandom_range(86399);
                end else if ($urandom_range(1)) begin
                    secs = $urandom_range(2);
                end else begin
                    secs = $urandom_range(86399, 86397);
                end
                send_word(31'(day * 86400 + secs), !(n >= 400 && n < 600));
            end
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (DrainCycles) @(posedge i_clk);

        $display("checked %0d date words, %0d falling in leap years, %0d on February 29",
                 words_checked, leap_year_words, leap_day_words);
        $display("range ends, day/month/leap edges, %0d random words, gaps both sides, %0d-cycle hold-off",
                 RandomWords, HoldCycles);
        if (fail_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned cyc;
        out_ch.ready = 1'b0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == HoldStart) begin
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                cyc += HoldCycles;
            end
            if (cyc >= CalmStart && cyc < CalmEnd) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin : watchdog
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/esc_pkg.sv
design/esc_if.sv
design/esc_cmp_sub.sv
design/epoch_seconds_to_calendar_date_unit.sv
tb/esc_date_checker.sv
tb/tb_epoch_seconds_to_calendar_date_unit.sv
